[src/tdp_pkg.sv]
package tdp_pkg;

    // width of the value field on the input port
    localparam int VALUE_FIELD_WIDTH = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCREEN,
        S_DIVIDE,
        S_JUDGE
    } tdp_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture value, set divisor to three
        logic div_start;   // clear remainder, load quotient with value
        logic div_step;    // one restoring division step
        logic next_div;    // advance divisor to the next odd number
        logic finish;      // write the verdict and raise done
        logic result;      // verdict written on finish
    } tdp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic below_two;      // value is zero or one
        logic even;           // value is even
        logic is_two;         // value is two
        logic div_last;       // current step is the last one of the division
        logic bound_passed;   // divisor exceeds quotient, no divisor left
        logic rem_zero;       // remainder of the last division is zero
    } tdp_status_t;

endpackage

[src/tdp_datapath.sv]
module tdp_datapath
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [VALUE_FIELD_WIDTH-1:0] value,
    input  tdp_cmd_t                     cmd,
    output tdp_status_t                  status,
    output logic                         done,
    output logic                         is_prime
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

    logic [W-1:0]  v_reg;
    logic [W-1:0]  d_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quot_reg;
    logic [CW-1:0] count_reg;
    logic          done_reg;
    logic          is_prime_reg;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          fits;

    // one restoring division step
    always_comb
    begin
        shifted = {rem_reg, quot_reg[W-1]};
        diff    = shifted - {1'b0, d_reg};
        fits    = ~diff[W];
    end

    // value and divisor
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg <= W'(value);
            d_reg <= W'(3);
        end
        else if (cmd.next_div)
        begin
            d_reg <= d_reg + W'(2);
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quot_reg <= v_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? diff[W-1:0] : shifted[W-1:0];
            quot_reg <= {quot_reg[W-2:0], fits};
        end
    end

    // division step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            count_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // result strobe and verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            is_prime_reg <= cmd.result;
        end
    end

    // status to the controller
    always_comb
    begin
        status.below_two    = (v_reg[W-1:1] == '0);
        status.even         = ~v_reg[0];
        status.is_two       = (v_reg == W'(2));
        status.div_last     = (count_reg == LAST_STEP);
        status.bound_passed = (d_reg > quot_reg);
        status.rem_zero     = (rem_reg == '0);
    end

    assign done     = done_reg;
    assign is_prime = is_prime_reg;

    // a result is a single-cycle strobe that follows a finish command
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done_reg)
        else $error("finish did not raise done");

    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (count_reg == '0))
        else $error("division start did not clear the step count");

endmodule

[src/tdp_controller.sv]
module tdp_controller
    import tdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  tdp_status_t status,
    output tdp_cmd_t    cmd,
    output logic        busy
);

    tdp_state_t state_reg;
    tdp_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCREEN;
                end
            end
            S_SCREEN:
            begin
                if (status.below_two || status.even)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                if (status.bound_passed || status.rem_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_SCREEN:
            begin
                priority if (status.below_two)
                begin
                    cmd.finish = 1'b1;
                    cmd.result = 1'b0;
                end
                else if (status.even)
                begin
                    cmd.finish = 1'b1;
                    cmd.result = status.is_two;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            S_JUDGE:
            begin
                priority if (status.bound_passed)
                begin
                    cmd.finish = 1'b1;
                    cmd.result = 1'b1;
                end
                else if (status.rem_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.result = 1'b0;
                end
                else
                begin
                    cmd.next_div  = 1'b1;
                    cmd.div_start = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // sequencing checks
    a_accept_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_SCREEN))
        else $error("accepted item did not enter screening");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");

    a_divide_judge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && status.div_last) |=> (state_reg == S_JUDGE))
        else $error("last division step did not lead to judging");

endmodule

[src/trial_division_primality_test.sv]
// trial division primality test
//
// input: drive value and raise start; the transfer happens at the rising
// edge where start is high and busy is low. busy stays high while a test
// runs, and no new value is taken until it drops.
// output: done is high for exactly one cycle with is_prime valid in that
// cycle; the receiver cannot hold results off, so it must take the
// transfer in that cycle.
// sequence: for 0, 1 and even values the verdict is given straight from
// screening after the accepting edge, with no division. for odd values
// the block tries odd divisors from three upward, up to about
// 2^(VALUE_WIDTH/2 - 1) of them. each divisor costs one bit-serial restoring
// division of VALUE_WIDTH steps, after which the result is judged.
// flow: one value at a time; busy drops in the cycle done rises, so
// the next value may be accepted at the edge that ends that cycle.
// reset: asynchronous active-low rst_n returns the block to idle with no
// result pending.
module trial_division_primality_test
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [VALUE_FIELD_WIDTH-1:0] value,
    output logic                         done,
    output logic                         is_prime
);

    tdp_cmd_t    cmd;
    tdp_status_t status;

    // sequencer
    tdp_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // divider, divisor and result registers
    tdp_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .cmd      (cmd),
        .status   (status),
        .done     (done),
        .is_prime (is_prime)
    );

endmodule
